// ----- rtl/ftc_pkg.sv -----
`default_nettype none
package ftc_pkg;

    localparam int unsigned DEF_FLOW_SLOTS = 64;
    localparam logic [63:0] DEF_IDLE_TIMEOUT = 64'd60000000000;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = 1;
    localparam int unsigned IN_TDATA_W = 264;
    localparam int unsigned OUT_TDATA_W = 152;

    typedef enum logic [1:0] {
        REQ_PACKET   = 2'd0,
        REQ_SNAPSHOT = 2'd1,
        REQ_SWEEP    = 2'd2,
        REQ_UNUSED   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0,
        ST_NEW     = 2'd1,
        ST_FULL    = 2'd2,
        ST_SWEEP   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ENG_CLEAR,
        ENG_IDLE,
        ENG_SCAN,
        ENG_UPDATE
    } eng_state_t;

    // classified request as it waits in the queue
    typedef struct packed {
        req_t        req;
        logic [63:0] addr;
        logic [39:0] ppr;
        logic [31:0] byte_count;
        logic [31:0] rx_level;
        logic [31:0] tx_level;
        logic [63:0] now_ns;
        logic        mcast;
    } ftc_item_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] addr;
        logic [39:0] ppr;
        logic [63:0] byte_total;
        logic [31:0] packet_total;
        logic [63:0] last_time;
        logic [31:0] prev_rx;
        logic [31:0] prev_tx;
    } ftc_entry_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  slot_index;
        logic        event_valid;
        logic [32:0] event_bytes;
        logic        mcast;
        logic [63:0] total_bytes;
        logic [31:0] total_packets;
        logic [6:0]  aged_count;
        logic [6:0]  flow_count;
    } ftc_result_t;

endpackage
`default_nettype wire

// ----- rtl/flow_table_counter.sv -----
// Flow table counter: a table of FLOW_SLOTS flows keyed by the five-tuple.
// Input channel s_*: one request per handshake; s_tuser carries the request
// kind (packet, queue snapshot, aging sweep; code 3 is swallowed with no
// result). Output channel m_*: one result per request, m_tuser is the status.
// cfg_we/cfg_wdata load the 64-bit idle timeout at any edge with cfg_we high.
// Requests land in a two-entry queue; the back end then walks the table
// memory one slot per cycle through its single read port. A packet or
// snapshot scan stops at the first key match, a sweep walks every slot;
// each request is first fetched from the queue in the idle state.
// After reset the back end clears the valid flag of every slot, one slot a
// cycle; requests queue up meanwhile and the queue fills after two. The
// timeout resets to 60 s.
// When m_tready is low the result waits in the output register; the back end
// holds in its write-back step and the front keeps taking requests until the
// queue is full, then drops s_tready.
`default_nettype none
module flow_table_counter #(
    parameter int unsigned FLOW_SLOTS = ftc_pkg::DEF_FLOW_SLOTS
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // src_ip, dst_ip, source port, destination port, protocol, byte_count,
    // rx level, tx level, now_ns
    input  wire  [ftc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // req_type
    input  wire  [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // slot_index, event_valid, event_bytes, multicast flag, total_bytes,
    // total_packets, aged_count, valid flow count, one zero pad bit
    output logic [ftc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // status
    output logic [1:0]                         m_tuser,
    input  wire                                cfg_we,
    input  wire  [63:0]                        cfg_wdata
);
    import ftc_pkg::*;

    logic [63:0]  timeout_reg;
    ftc_item_t    q_item;
    logic         q_valid;
    logic         q_pop;
    ftc_result_t  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= DEF_IDLE_TIMEOUT;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    ftc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    ftc_engine #(
        .FLOW_SLOTS (FLOW_SLOTS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .idle_timeout (timeout_reg),
        .res          (res),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready)
    );

    assign m_tuser = res.status;
    assign m_tdata = {1'b0, res.flow_count, res.aged_count, res.total_packets,
                      res.total_bytes, res.mcast, res.event_bytes,
                      res.event_valid, res.slot_index};

endmodule
`default_nettype wire

// ----- rtl/ftc_front.sv -----
`default_nettype none
module ftc_front (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [ftc_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire  [1:0]                       s_tuser,
    output ftc_pkg::ftc_item_t               q_item,
    output logic                             q_valid,
    input  wire                              q_pop
);
    import ftc_pkg::*;

    ftc_item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]       count_reg, count_next;
    ftc_item_t             item;
    logic                  push;
    logic                  pop;

    always_comb
    begin
        item.req          = req_t'(s_tuser);
        item.addr         = {s_tdata[31:0], s_tdata[63:32]};
        item.ppr          = {s_tdata[79:64], s_tdata[95:80], s_tdata[103:96]};
        item.byte_count   = s_tdata[135:104];
        item.rx_level     = s_tdata[167:136];
        item.tx_level     = s_tdata[199:168];
        item.now_ns       = s_tdata[263:200];
        item.mcast        = (s_tdata[63:60] == 4'hE);
    end

    assign s_tready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    // drop the unused request code at the door
    assign push = s_tvalid && s_tready && (item.req != REQ_UNUSED);
    assign pop  = q_pop && q_valid;
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ftc_engine.sv -----
`default_nettype none
module ftc_engine #(
    parameter int unsigned FLOW_SLOTS = ftc_pkg::DEF_FLOW_SLOTS
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ftc_pkg::ftc_item_t   q_item,
    input  wire                  q_valid,
    output logic                 q_pop,
    input  wire  [63:0]          idle_timeout,
    output ftc_pkg::ftc_result_t res,
    output logic                 res_valid,
    input  wire                  res_ready
);
    import ftc_pkg::*;

    localparam int unsigned IDX_W = $clog2(FLOW_SLOTS);
    localparam int unsigned CNT_W = $clog2(FLOW_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_SLOTS - 1);

    ftc_entry_t         mem [FLOW_SLOTS];
    ftc_entry_t         rd_data_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    ftc_entry_t         wr_data;

    eng_state_t         state_reg, state_next;
    ftc_item_t          work_reg, work_next;
    logic [IDX_W-1:0]   clr_ptr_reg, clr_ptr_next;
    logic [IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic               issuing_reg, issuing_next;
    logic               eval_vld_reg, eval_vld_next;
    logic [IDX_W-1:0]   eval_idx_reg, eval_idx_next;
    logic               hit_reg, hit_next;
    logic               free_reg, free_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    ftc_entry_t         hit_data_reg, hit_data_next;
    logic [CNT_W-1:0]   aged_reg, aged_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               res_valid_reg, res_valid_next;
    ftc_result_t        res_reg, res_next;

    logic               match;
    logic               aged_hit;
    logic [63:0]        idle_ns;
    logic               out_free;
    ftc_entry_t         base;
    logic [32:0]        drx;
    logic [32:0]        dtx;
    logic [32:0]        ev;
    logic [64:0]        bsum;
    logic [63:0]        new_bytes;
    logic [31:0]        new_pkts;
    logic               bump;
    logic [IDX_W+5:0]   slot_wide;
    logic [CNT_W+6:0]   cnt_wide;
    logic [CNT_W+6:0]   aged_wide;

    assign idle_ns  = work_reg.now_ns - rd_data_reg.last_time;
    assign match    = rd_data_reg.valid && (rd_data_reg.addr == work_reg.addr)
                      && (rd_data_reg.ppr == work_reg.ppr);
    assign aged_hit = rd_data_reg.valid && (rd_data_reg.last_time != '0)
                      && (idle_ns > idle_timeout);
    assign out_free = !res_valid_reg || res_ready;

    // entry update arithmetic
    always_comb
    begin
        base = hit_reg ? hit_data_reg : '0;
        drx  = (work_reg.rx_level >= base.prev_rx)
               ? {1'b0, work_reg.rx_level - base.prev_rx} : '0;
        dtx  = (work_reg.tx_level >= base.prev_tx)
               ? {1'b0, work_reg.tx_level - base.prev_tx} : '0;
        if (work_reg.req == REQ_PACKET)
        begin
            ev = {1'b0, work_reg.byte_count};
        end
        else
        begin
            ev = drx + dtx;
        end
        bump      = (work_reg.req == REQ_PACKET) || (ev != '0);
        bsum      = {1'b0, base.byte_total} + {32'b0, ev};
        new_bytes = bsum[64] ? '1 : bsum[63:0];
        new_pkts  = (bump && (base.packet_total != '1))
                    ? base.packet_total + 32'd1 : base.packet_total;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENG_CLEAR:
            begin
                if (clr_ptr_reg == LAST_IDX)
                begin
                    state_next = ENG_IDLE;
                end
            end
            ENG_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ENG_SCAN;
                end
            end
            ENG_SCAN:
            begin
                if (eval_vld_reg && ((match && work_reg.req != REQ_SWEEP)
                                     || eval_idx_reg == LAST_IDX))
                begin
                    state_next = ENG_UPDATE;
                end
            end
            ENG_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_comb
    begin
        work_next      = work_reg;
        clr_ptr_next   = clr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        issuing_next   = issuing_reg;
        eval_vld_next  = 1'b0;
        eval_idx_next  = rd_ptr_reg;
        hit_next       = hit_reg;
        free_next      = free_reg;
        slot_next      = slot_reg;
        hit_data_next  = hit_data_reg;
        aged_next      = aged_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = rd_ptr_reg;
        wr_en          = 1'b0;
        wr_addr        = eval_idx_reg;
        wr_data        = rd_data_reg;
        slot_wide      = '0;
        cnt_wide       = '0;
        aged_wide      = '0;
        case (state_reg)
            ENG_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_ptr_reg;
                wr_data      = '0;
                clr_ptr_next = clr_ptr_reg + 1'b1;
            end
            ENG_IDLE:
            begin
                q_pop        = 1'b1;
                work_next    = q_item;
                rd_ptr_next  = '0;
                issuing_next = 1'b1;
                hit_next     = 1'b0;
                free_next    = 1'b0;
                slot_next    = '0;
                aged_next    = '0;
            end
            ENG_SCAN:
            begin
                if (issuing_reg)
                begin
                    rd_en         = 1'b1;
                    eval_vld_next = 1'b1;
                    rd_ptr_next   = rd_ptr_reg + 1'b1;
                    if (rd_ptr_reg == LAST_IDX)
                    begin
                        issuing_next = 1'b0;
                    end
                end
                if (eval_vld_reg)
                begin
                    if (work_reg.req == REQ_SWEEP)
                    begin
                        if (aged_hit)
                        begin
                            wr_en         = 1'b1;
                            wr_data.valid = 1'b0;
                            aged_next     = aged_reg + 1'b1;
                            cnt_next      = cnt_reg - 1'b1;
                        end
                    end
                    else if (match)
                    begin
                        hit_next      = 1'b1;
                        slot_next     = eval_idx_reg;
                        hit_data_next = rd_data_reg;
                    end
                    else if (!rd_data_reg.valid && !free_reg)
                    begin
                        free_next = 1'b1;
                        slot_next = eval_idx_reg;
                    end
                end
            end
            ENG_UPDATE:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                    if (work_reg.req == REQ_SWEEP)
                    begin
                        res_next.status = ST_SWEEP;
                        aged_wide       = {7'b0, aged_reg};
                        res_next.aged_count = aged_wide[6:0];
                    end
                    else
                    begin
                        res_next.mcast = work_reg.mcast;
                        if (!hit_reg && !free_reg)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = slot_reg;
                            wr_data.valid        = 1'b1;
                            wr_data.addr         = work_reg.addr;
                            wr_data.ppr          = work_reg.ppr;
                            wr_data.byte_total   = new_bytes;
                            wr_data.packet_total = new_pkts;
                            wr_data.last_time    = work_reg.now_ns;
                            wr_data.prev_rx      = (work_reg.req == REQ_SNAPSHOT)
                                                   ? work_reg.rx_level : base.prev_rx;
                            wr_data.prev_tx      = (work_reg.req == REQ_SNAPSHOT)
                                                   ? work_reg.tx_level : base.prev_tx;
                            if (!hit_reg)
                            begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                            res_next.status        = hit_reg ? ST_UPDATED : ST_NEW;
                            slot_wide              = {6'b0, slot_reg};
                            res_next.slot_index    = slot_wide[5:0];
                            res_next.event_valid   = (ev != '0);
                            res_next.event_bytes   = ev;
                            res_next.total_bytes   = new_bytes;
                            res_next.total_packets = new_pkts;
                        end
                    end
                    cnt_wide            = {7'b0, cnt_next};
                    res_next.flow_count = cnt_wide[6:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_CLEAR;
            clr_ptr_reg   <= '0;
            rd_ptr_reg    <= '0;
            issuing_reg   <= 1'b0;
            eval_vld_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            aged_reg      <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            issuing_reg   <= issuing_next;
            eval_vld_reg  <= eval_vld_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            aged_reg      <= aged_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        eval_idx_reg <= eval_idx_next;
        slot_reg     <= slot_next;
        hit_data_reg <= hit_data_next;
        res_reg      <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule
`default_nettype wire

// ----- rtl/ftc_checker.sv -----
`default_nettype none
module ftc_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [ftc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input wire [1:0]                         m_tuser
);
    import ftc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // event flag follows the event byte count
    a_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6] == (m_tdata[39:7] != '0)))
        else $error("event_valid disagrees with event_bytes");

    // a sweep reports no slot, event, multicast flag or totals
    a_sweep_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_SWEEP |-> m_tdata[136:0] == '0)
        else $error("sweep result carries flow data");

    // a dropped request leaves slot, event and totals at zero
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_FULL |->
            m_tdata[39:0] == '0 && m_tdata[143:41] == '0)
        else $error("dropped request carries flow data");

endmodule

bind flow_table_counter ftc_checker u_ftc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ----- verif/flow_table_counter_test.sv -----
`default_nettype none
module flow_table_counter_test;
    import ftc_pkg::*;

    localparam int SLOTS = DEF_FLOW_SLOTS;
    localparam int KEY_POOL = 80;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = SLOTS + 16;

    typedef struct {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
        logic [31:0] byte_count;
        logic [31:0] rx_level;
        logic [31:0] tx_level;
        logic [63:0] now_ns;
    } flow_req_t;

    class flow_scoreboard;
        logic        valid [SLOTS];
        logic [63:0] addr [SLOTS];
        logic [39:0] ppr [SLOTS];
        logic [63:0] byte_total [SLOTS];
        logic [31:0] pkt_total [SLOTS];
        logic [63:0] last_time [SLOTS];
        logic [31:0] prev_rx [SLOTS];
        logic [31:0] prev_tx [SLOTS];
        logic [6:0]  active;
        logic [63:0] idle_timeout;
        ftc_result_t pending [$];
        int errors;
        int n_new, n_full, n_sweeps, n_freed, n_checked;

        function void clear();
            foreach (valid[i]) valid[i] = 1'b0;
            active = 0;
            idle_timeout = DEF_IDLE_TIMEOUT;
            errors = 0;
            n_new = 0;
            n_full = 0;
            n_sweeps = 0;
            n_freed = 0;
            n_checked = 0;
        endfunction

        function void note_request(req_t r, flow_req_t q);
            ftc_result_t e;
            logic [63:0] a;
            logic [39:0] p;
            logic [64:0] sum;
            logic [32:0] ev;
            int s;
            bit fresh;
            e = '0;
            if (r == REQ_UNUSED)
                return;
            if (r == REQ_SWEEP) begin
                for (int i = 0; i < SLOTS; i++)
                    if (valid[i] && last_time[i] != 0
                        && (q.now_ns - last_time[i]) > idle_timeout) begin
                        valid[i] = 1'b0;
                        active--;
                        e.aged_count++;
                    end
                e.status = ST_SWEEP;
                e.flow_count = active;
                n_sweeps++;
                n_freed += e.aged_count;
                pending.push_back(e);
                return;
            end
            a = {q.src_ip, q.dst_ip};
            p = {q.sport, q.dport, q.protocol};
            e.mcast = (q.dst_ip[31:28] == 4'hE);
            s = -1;
            fresh = 0;
            for (int i = 0; i < SLOTS && s < 0; i++)
                if (valid[i] && addr[i] == a && ppr[i] == p)
                    s = i;
            for (int i = 0; i < SLOTS && s < 0; i++)
                if (!valid[i]) begin
                    s = i;
                    fresh = 1;
                    valid[i] = 1'b1;
                    addr[i] = a;
                    ppr[i] = p;
                    byte_total[i] = 0;
                    pkt_total[i] = 0;
                    prev_rx[i] = 0;
                    prev_tx[i] = 0;
                    active++;
                end
            if (s < 0) begin
                e.status = ST_FULL;
                e.flow_count = active;
                n_full++;
                pending.push_back(e);
                return;
            end
            if (r == REQ_PACKET)
                ev = {1'b0, q.byte_count};
            else begin
                ev = ((q.rx_level >= prev_rx[s]) ? {1'b0, q.rx_level - prev_rx[s]} : 33'd0)
                   + ((q.tx_level >= prev_tx[s]) ? {1'b0, q.tx_level - prev_tx[s]} : 33'd0);
                prev_rx[s] = q.rx_level;
                prev_tx[s] = q.tx_level;
            end
            sum = {1'b0, byte_total[s]} + ev;
            byte_total[s] = sum[64] ? '1 : sum[63:0];
            if ((r == REQ_PACKET || ev != 0) && pkt_total[s] != '1)
                pkt_total[s]++;
            last_time[s] = q.now_ns;
            if (fresh)
                n_new++;
            e.status = fresh ? ST_NEW : ST_UPDATED;
            e.slot_index = s[5:0];
            e.event_valid = (ev != 0);
            e.event_bytes = ev;
            e.total_bytes = byte_total[s];
            e.total_packets = pkt_total[s];
            e.flow_count = active;
            pending.push_back(e);
        endfunction

        function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] st, logic [OUT_TDATA_W-1:0] d);
            ftc_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status %h data %h", $time, st, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            compare("status", e.status, st);
            compare("slot_index", e.slot_index, d[5:0]);
            compare("event_valid", e.event_valid, d[6]);
            compare("event_bytes", e.event_bytes, d[39:7]);
            compare("multicast", e.mcast, d[40]);
            compare("total_bytes", e.total_bytes, d[104:41]);
            compare("total_packets", e.total_packets, d[136:105]);
            compare("aged_count", e.aged_count, d[143:137]);
            compare("flow_count", e.flow_count, d[150:144]);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_we = 1'b0;
    logic [63:0] cfg_wdata = '0;

    flow_scoreboard flows;
    flow_req_t key_pool [KEY_POOL];
    logic [63:0] clock_ns;
    int idle_cycles = 0;
    bit rx_steady;
    int rx_hold = 0;

    flow_table_counter dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result side: check, then pick the next ready value
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            flows.check_result(m_tuser, m_tdata);
        if (rx_steady)
            m_tready <= 1'b1;
        else if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            rx_hold <= $urandom_range(30, 150);
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            rx_hold <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("timeout with %0d results outstanding", flows.pending.size());
            $display("flow_table_counter: mismatch");
            $finish;
        end
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 60);
    endfunction

    task automatic send_request(req_t r, flow_req_t q, bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r;
        s_tdata <= {q.now_ns, q.tx_level, q.rx_level, q.byte_count, q.protocol,
                    q.dport, q.sport, q.dst_ip, q.src_ip};
        do
            @(posedge clk);
        while (!s_tready);
        flows.note_request(r, q);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (flows.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_timeout(logic [63:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        flows.idle_timeout = v;
    endtask

    function automatic flow_req_t random_fields();
        flow_req_t q;
        q.src_ip = $urandom;
        q.dst_ip = $urandom;
        q.sport = $urandom;
        q.dport = $urandom;
        q.protocol = $urandom;
        q.byte_count = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
        q.rx_level = $urandom;
        q.tx_level = $urandom;
        q.now_ns = clock_ns;
        return q;
    endfunction

    // mostly known flows so entries get hit again; now and then a fresh one
    function automatic flow_req_t pick_flow();
        flow_req_t q;
        flow_req_t k;
        q = random_fields();
        if ($urandom_range(0, 9) < 8)
        begin
            k = key_pool[$urandom_range(0, KEY_POOL - 1)];
            q.src_ip = k.src_ip;
            q.dst_ip = k.dst_ip;
            q.sport = k.sport;
            q.dport = k.dport;
            q.protocol = k.protocol;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            q.rx_level = $urandom_range(0, 1000);
            q.tx_level = $urandom_range(0, 1000);
        end
        return q;
    endfunction

    task automatic random_phase(int count, bit pause_midway);
        flow_req_t q;
        int sel;
        req_t r;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 3))
                0: clock_ns = clock_ns + $urandom_range(1000, 5000);
                default: clock_ns = clock_ns + $urandom_range(0, 300);
            endcase
            q = pick_flow();
            sel = $urandom_range(0, 99);
            if (sel < 46)
                r = REQ_PACKET;
            else if (sel < 84)
                r = REQ_SNAPSHOT;
            else if (sel < 97)
                r = REQ_SWEEP;
            else
                r = REQ_UNUSED;
            if ($urandom_range(0, 49) == 0)
                q.now_ns = $urandom;
            if (r != REQ_UNUSED)
                sent++;
            send_request(r, q, 1'b1);
            if (pause_midway && sent == count / 2)
            begin
                s_tvalid <= 1'b0;
                while (flows.pending.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
        end
    endtask

    initial
    begin
        flow_req_t q;
        flow_req_t base;
        flows = new();
        flows.clear();
        rx_steady = 1'b0;
        clock_ns = 64'd1000;
        foreach (key_pool[i])
        begin
            key_pool[i] = random_fields();
            if (i % 5 == 0)
                key_pool[i].dst_ip[31:28] = 4'hE;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: time zero entry, extremes, shrink, multicast, unused code, sweeps
        base = random_fields();
        base.now_ns = 64'd0;
        send_request(REQ_PACKET, base, 1'b0);
        base.byte_count = 32'd0;
        send_request(REQ_PACKET, base, 1'b0);
        q = base;
        q.src_ip = 32'hFFFF_FFFF; q.dst_ip = 32'hFFFF_FFFF;
        q.sport = 16'hFFFF; q.dport = 16'hFFFF; q.protocol = 8'hFF;
        q.rx_level = 32'hFFFF_FFFF; q.tx_level = 32'hFFFF_FFFF; q.now_ns = 64'd5;
        send_request(REQ_SNAPSHOT, q, 1'b0);
        q.rx_level = 32'd0; q.tx_level = 32'd0; q.now_ns = 64'd6;
        send_request(REQ_SNAPSHOT, q, 1'b0);
        q.rx_level = 32'd7; q.tx_level = 32'd9;
        send_request(REQ_SNAPSHOT, q, 1'b0);
        q = random_fields();
        q.src_ip = '0; q.dst_ip = '0; q.sport = '0; q.dport = '0; q.protocol = '0;
        q.byte_count = 32'hFFFF_FFFF;
        send_request(REQ_PACKET, q, 1'b0);
        q.dst_ip = 32'hE000_0001;
        send_request(REQ_PACKET, q, 1'b0);
        q.dst_ip = 32'hEFFF_FFFF;
        send_request(REQ_SNAPSHOT, q, 1'b0);
        q.dst_ip = 32'hF000_0000;
        send_request(REQ_PACKET, q, 1'b0);
        send_request(REQ_UNUSED, q, 1'b0);
        q.now_ns = 64'd60000001000;
        send_request(REQ_SWEEP, q, 1'b0);
        q.now_ns = '1;
        send_request(REQ_SWEEP, q, 1'b0);
        send_request(REQ_PACKET, base, 1'b0);

        // overfill the table, then age every flow with a nonzero timestamp using a zero timeout
        load_timeout('1);
        for (int i = 0; i < SLOTS + 6; i++)
        begin
            q = random_fields();
            q.now_ns = clock_ns + i;
            send_request(i % 2 ? REQ_SNAPSHOT : REQ_PACKET, q, 1'b0);
        end
        clock_ns = clock_ns + 100;
        q.now_ns = clock_ns;
        send_request(REQ_SWEEP, q, 1'b0);
        load_timeout('0);
        q.now_ns = clock_ns + 1;
        send_request(REQ_SWEEP, q, 1'b0);

        random_phase(250, 1'b1);
        load_timeout(64'd1500);
        random_phase(250, 1'b0);
        load_timeout(64'd40000);
        rx_steady = 1'b1;
        random_phase(150, 1'b0);
        rx_steady = 1'b0;
        load_timeout(64'd0);
        random_phase(150, 1'b0);
        load_timeout(DEF_IDLE_TIMEOUT);
        random_phase(200, 1'b0);
        load_timeout(64'd3000);
        random_phase(200, 1'b0);

        drain();
        if (flows.pending.size() != 0)
            flows.errors++;
        $display("checked %0d results: %0d new flows, %0d drops on a full table",
                 flows.n_checked, flows.n_new, flows.n_full);
        $display("%0d sweeps freed %0d flows over six timeout settings",
                 flows.n_sweeps, flows.n_freed);
        if (flows.errors == 0)
            $display("flow_table_counter: match");
        else
            $display("flow_table_counter: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/ftc_pkg.sv
rtl/ftc_front.sv
rtl/ftc_engine.sv
rtl/flow_table_counter.sv
rtl/ftc_checker.sv
verif/flow_table_counter_test.sv
